[hdl/smbf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbf_pkg
// Shared types and constants of the structure table walker: register
// indexes, result status codes and the structs passed between stages.
// ----------------------------------------------------------------------------
package smbf_pkg;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WANTED_TYPE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WANTED_INSTANCE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TABLE_LENGTH    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STRUCTURE_LIMIT = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_FOUND        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND    = 2'd1;
    localparam logic [1:0] STATUS_BEYOND_TABLE = 2'd2;
    localparam logic [1:0] STATUS_UNTERMINATED = 2'd3;

    localparam logic [7:0]  END_OF_TABLE_TYPE = 8'd127;
    localparam logic [33:0] HEADER_BYTES      = 34'd4;

    // configuration register set
    typedef struct packed {
        logic [7:0]  wanted_type;
        logic [15:0] wanted_instance;
        logic [31:0] table_length;
        logic [15:0] structure_limit;
    } cfg_t;

    // one table byte request
    typedef struct packed {
        logic [7:0] table_byte;
        logic       walk_start;
    } item_t;

    // walker step outcome
    typedef struct packed {
        logic        emit;
        logic [1:0]  walk_status;
        logic [31:0] structure_offset;
        logic [7:0]  formatted_length;
    } step_t;

endpackage

[hdl/smbf_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbf_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module smbf_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [smbf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [31:0]                      cfg_wdata,
    output smbf_pkg::cfg_t                   cfg
);

    smbf_pkg::cfg_t cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                smbf_pkg::CFG_WANTED_TYPE:     cfg_reg.wanted_type     <= cfg_wdata[7:0];
                smbf_pkg::CFG_WANTED_INSTANCE: cfg_reg.wanted_instance <= cfg_wdata[15:0];
                smbf_pkg::CFG_TABLE_LENGTH:    cfg_reg.table_length    <= cfg_wdata;
                smbf_pkg::CFG_STRUCTURE_LIMIT: cfg_reg.structure_limit <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/smbf_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbf_in_stage
// Input register: holds one byte request until the walker consumes it.
// ----------------------------------------------------------------------------
module smbf_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_table_byte,
    input  logic                s_walk_start,
    input  logic                consume,
    output logic                item_valid,
    output smbf_pkg::item_t     item
);

    logic            valid_reg;
    smbf_pkg::item_t item_reg;

    // free when empty or emptied this cycle
    assign s_ready = !valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (consume) begin
            valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.table_byte <= s_table_byte;
            item_reg.walk_start <= s_walk_start;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/smbf_walker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbf_walker
// Per-byte structure walk: header decode, bounds checks, string-set
// terminator search, structure counting and type matching.
// ----------------------------------------------------------------------------
module smbf_walker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              walk_en,
    input  smbf_pkg::item_t   item,
    input  smbf_pkg::cfg_t    cfg,
    output smbf_pkg::step_t   step
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LENGTH,
        PH_SCAN,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next, eff_phase;
    logic [31:0] pos_reg, eff_pos;
    logic [31:0] hdr_reg, hdr_next, eff_hdr;
    logic [32:0] ss_reg, ss_next, eff_ss;
    logic [7:0]  ctype_reg, ctype_next, eff_ctype;
    logic [7:0]  clen_reg, clen_next, eff_clen;
    logic [7:0]  prev_reg, eff_prev;
    logic [15:0] inst_reg, inst_next, eff_inst;
    logic [15:0] seen_reg, seen_next, eff_seen;

    logic [7:0]  b;
    logic        start;
    logic [32:0] len_ss;
    logic [32:0] scan_ss;
    logic [7:0]  scan_clen;
    logic [32:0] next_pos;
    logic [15:0] seen_inc;
    logic        limit_on;
    logic        room_hdr;
    logic        room_next;
    logic        pair_end;
    logic        no_fit;
    logic        type_match;

    assign b     = item.table_byte;
    assign start = item.walk_start;

    // state as seen by this byte, restart applied
    always_comb begin
        eff_phase = start ? PH_TYPE     : phase_reg;
        eff_pos   = start ? 32'd0       : pos_reg;
        eff_hdr   = start ? 32'd0       : hdr_reg;
        eff_ss    = start ? 33'd0       : ss_reg;
        eff_ctype = start ? 8'd0        : ctype_reg;
        eff_clen  = start ? 8'd0        : clen_reg;
        eff_prev  = start ? 8'hFF       : prev_reg;
        eff_inst  = start ? cfg.wanted_instance : inst_reg;
        eff_seen  = start ? 16'd0       : seen_reg;
    end

    // bounds and terminator checks
    always_comb begin
        limit_on   = cfg.structure_limit != 16'd0;
        len_ss     = {1'b0, eff_hdr} + {25'd0, b};
        scan_ss    = (eff_phase == PH_LENGTH) ? len_ss : eff_ss;
        scan_clen  = (eff_phase == PH_LENGTH) ? b : eff_clen;
        next_pos   = {1'b0, eff_pos} + 33'd1;
        seen_inc   = eff_seen + 16'd1;
        type_match = eff_ctype == cfg.wanted_type;
        room_hdr   = ({2'b00, eff_hdr} + smbf_pkg::HEADER_BYTES < {2'b00, cfg.table_length})
                     && !(limit_on && eff_seen >= cfg.structure_limit);
        room_next  = ({1'b0, next_pos} + smbf_pkg::HEADER_BYTES < {2'b00, cfg.table_length})
                     && !(limit_on && seen_inc >= cfg.structure_limit);
        pair_end   = ({1'b0, eff_pos} > scan_ss) && (eff_prev == 8'd0) && (b == 8'd0);
        no_fit     = ({1'b0, eff_pos} + 33'd2) > {1'b0, cfg.table_length};
    end

    // next state and result
    always_comb begin
        phase_next = eff_phase;
        hdr_next   = eff_hdr;
        ss_next    = eff_ss;
        ctype_next = eff_ctype;
        clen_next  = eff_clen;
        inst_next  = eff_inst;
        seen_next  = eff_seen;
        step       = '0;

        unique case (eff_phase)
            PH_TYPE: begin
                if (!room_hdr) begin
                    step.emit        = 1'b1;
                    step.walk_status = smbf_pkg::STATUS_NOT_FOUND;
                    phase_next       = PH_DONE;
                end else begin
                    ctype_next = b;
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH, PH_SCAN: begin
                if (eff_phase == PH_LENGTH) begin
                    clen_next = b;
                    ss_next   = len_ss;
                end
                if (eff_phase == PH_LENGTH && len_ss > {1'b0, cfg.table_length}) begin
                    step.emit             = 1'b1;
                    step.walk_status      = smbf_pkg::STATUS_BEYOND_TABLE;
                    step.structure_offset = eff_hdr;
                    step.formatted_length = b;
                    phase_next            = PH_DONE;
                end else if (pair_end) begin
                    // structure finished
                    if (!limit_on && eff_ctype == smbf_pkg::END_OF_TABLE_TYPE) begin
                        step.emit        = 1'b1;
                        step.walk_status = smbf_pkg::STATUS_NOT_FOUND;
                        phase_next       = PH_DONE;
                    end else if (type_match && eff_inst == 16'd0) begin
                        step.emit             = 1'b1;
                        step.walk_status      = smbf_pkg::STATUS_FOUND;
                        step.structure_offset = eff_hdr;
                        step.formatted_length = scan_clen;
                        phase_next            = PH_DONE;
                    end else begin
                        if (type_match) begin
                            inst_next = eff_inst - 16'd1;
                        end
                        seen_next = seen_inc;
                        if (!room_next) begin
                            step.emit        = 1'b1;
                            step.walk_status = smbf_pkg::STATUS_NOT_FOUND;
                            phase_next       = PH_DONE;
                        end else begin
                            hdr_next   = next_pos[31:0];
                            phase_next = PH_TYPE;
                        end
                    end
                end else if (no_fit) begin
                    step.emit             = 1'b1;
                    step.walk_status      = smbf_pkg::STATUS_UNTERMINATED;
                    step.structure_offset = eff_hdr;
                    step.formatted_length = scan_clen;
                    phase_next            = PH_DONE;
                end else begin
                    phase_next = PH_SCAN;
                end
            end
            PH_DONE: ;
            default: ;
        endcase
    end

    // walk state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            pos_reg   <= 32'd0;
            hdr_reg   <= 32'd0;
            ss_reg    <= 33'd0;
            ctype_reg <= 8'd0;
            clen_reg  <= 8'd0;
            prev_reg  <= 8'hFF;
            inst_reg  <= 16'd0;
            seen_reg  <= 16'd0;
        end else if (walk_en) begin
            phase_reg <= phase_next;
            pos_reg   <= next_pos[31:0];
            hdr_reg   <= hdr_next;
            ss_reg    <= ss_next;
            ctype_reg <= ctype_next;
            clen_reg  <= clen_next;
            prev_reg  <= b;
            inst_reg  <= inst_next;
            seen_reg  <= seen_next;
        end
    end

    // a result always closes the walk
    a_emit_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_en && step.emit |=> phase_reg == PH_DONE)
        else $error("walk not closed after result");

    // a closed walk stays silent until restart
    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE && !start |-> !step.emit)
        else $error("result after walk end");

    // found only on the wanted type
    a_found_type: assert property (@(posedge aclk) disable iff (!aresetn)
        step.emit && step.walk_status == smbf_pkg::STATUS_FOUND |-> type_match)
        else $error("found on wrong type");

    // position steps by one per byte without restart
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_en && !start |=> pos_reg == $past(pos_reg) + 32'd1)
        else $error("byte position slip");

endmodule

[hdl/smbf_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbf_out_stage
// Result register: holds one result request until it is taken.
// ----------------------------------------------------------------------------
module smbf_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  smbf_pkg::step_t   step,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_walk_status,
    output logic [31:0]       m_structure_offset,
    output logic [7:0]        m_formatted_length
);

    logic        valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] offset_reg;
    logic [7:0]  length_reg;

    // room for a new result when empty or draining
    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= step.walk_status;
            offset_reg <= step.structure_offset;
            length_reg <= step.formatted_length;
        end
    end

    assign m_valid            = valid_reg;
    assign m_walk_status      = status_reg;
    assign m_structure_offset = offset_reg;
    assign m_formatted_length = length_reg;

endmodule

[hdl/smbios_structure_finder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbios_structure_finder
// Walks an SMBIOS structure table streamed one byte per request and reports
// the wanted instance of the wanted structure type, or why the walk failed.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_table_byte, s_walk_start
//  m_       out        m_valid/m_ready    m_walk_status, m_structure_offset,
//                                         m_formatted_length
//  cfg_     in         cfg_we             cfg_addr, cfg_wdata
//
// one byte per cycle while the result side has room; a byte goes input register ->
// walker -> result register, and a result is held in the result register until taken.
// reset (aresetn low, synchronous) empties both registers and restarts the
// walk state; configuration registers clear to zero.
// a held result stalls the walker only while m_ready is low; the input
// register keeps taking bytes whenever the walker moves.
// ----------------------------------------------------------------------------
module smbios_structure_finder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_table_byte,
    input  logic                             s_walk_start,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_walk_status,
    output logic [31:0]                      m_structure_offset,
    output logic [7:0]                       m_formatted_length,
    input  logic                             cfg_we,
    input  logic [smbf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [31:0]                      cfg_wdata
);

    smbf_pkg::cfg_t  cfg;
    smbf_pkg::item_t item;
    smbf_pkg::step_t step;
    logic            item_valid;
    logic            out_free;
    logic            walk_en;

    // walker moves when a byte waits and the result side has room
    assign walk_en = item_valid && out_free;

    smbf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    smbf_in_stage u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_table_byte (s_table_byte),
        .s_walk_start (s_walk_start),
        .consume      (walk_en),
        .item_valid   (item_valid),
        .item         (item)
    );

    smbf_walker u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .walk_en (walk_en),
        .item    (item),
        .cfg     (cfg),
        .step    (step)
    );

    smbf_out_stage u_out (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .load               (walk_en && step.emit),
        .step               (step),
        .free               (out_free),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_walk_status      (m_walk_status),
        .m_structure_offset (m_structure_offset),
        .m_formatted_length (m_formatted_length)
    );

endmodule
